>>> hw/rtl/gpr_pkg.sv
// Shared types and constants for the plasmid rescue Gillespie step block.
// Used by the controller, the datapath, the multiplier and the checker.
// No dependencies.
`default_nettype none

package gpr_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int CHUNK_BITS     = 32;
    localparam int RATE_BITS      = 24;
    localparam int COEF_BITS      = 32;
    localparam int PROB_BITS      = 17;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int NUM_PROP       = 5;
    localparam int PROP_IDX_BITS  = 3;
    localparam int OUT_USER_BITS  = 5;

    localparam logic [PROB_BITS-1:0] ONE_Q16 = 17'h1_0000;

    localparam logic [RATE_BITS-1:0] RATE_RESET       = 24'h01_0000;
    localparam logic [31:0]          INIT_WILD_RESET  = 32'd1000;
    localparam logic [31:0]          THRESHOLD_RESET  = 32'd1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_BIRTH_RATE_WILD   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BIRTH_RATE_MUTANT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEATH_BASE_MUTANT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CROWDING          = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRANSFER          = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MUTATION_PROB     = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INITIAL_WILD      = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RESCUE_THRESHOLD  = 3'd7;

    typedef enum logic [1:0] {
        OUTCOME_RUNNING,
        OUTCOME_EXTINCT,
        OUTCOME_RESCUED,
        OUTCOME_NOT_VIABLE
    } t_outcome;

    typedef enum logic [2:0] {
        RXN_WILD_BIRTH,
        RXN_MUTANT_BIRTH,
        RXN_WILD_DEATH,
        RXN_MUTANT_DEATH,
        RXN_TRANSFER,
        RXN_NONE
    } t_reaction;

    typedef enum logic [2:0] {
        MOP_CROWD,
        MOP_WM,
        MOP_A0,
        MOP_A1,
        MOP_A2,
        MOP_A3,
        MOP_A4,
        MOP_LHS
    } t_mul_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ISSUE,
        ST_MUL,
        ST_SUM,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic                     load_in;
        logic                     mul_start;
        t_mul_op                  mul_op;
        logic                     sum_step;
        logic                     scan_step;
        logic [PROP_IDX_BITS-1:0] idx;
        logic                     commit_end;
        logic                     commit_react;
    } t_dp_cmd;

    typedef struct packed {
        logic must_end;
        logic mul_done;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hw/rtl/gpr_mul.sv
// Multi-cycle multiplier: one 32-bit chunk of the A operand per cycle,
// partial products registered and accumulated in the following cycle.
// Depends on gpr_pkg.
`default_nettype none

module gpr_mul #(
    parameter int A_BITS = 61,
    parameter int B_BITS = 33
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [A_BITS-1:0]   i_a,
    input  wire logic [B_BITS-1:0]   i_b,
    output logic                     o_done,
    output logic [((A_BITS + gpr_pkg::CHUNK_BITS - 1) / gpr_pkg::CHUNK_BITS)
                  * gpr_pkg::CHUNK_BITS + B_BITS - 1:0] o_p
);
    import gpr_pkg::*;

    localparam int NCH = (A_BITS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int AP  = NCH * CHUNK_BITS;
    localparam int PP  = CHUNK_BITS + B_BITS;
    localparam int PW  = AP + B_BITS;
    localparam int CW  = $clog2(NCH + 1);

    logic [AP-1:0]     r_a;
    logic [B_BITS-1:0] r_b;
    logic              r_busy;
    logic [CW-1:0]     r_cnt;
    logic [PP-1:0]     r_pp;
    logic              r_pp_valid;
    logic [CW-1:0]     r_acc_idx;
    logic [PW-1:0]     r_acc;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pp_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done     <= r_pp_valid && (r_acc_idx == CW'(NCH - 1));
            r_pp_valid <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(NCH - 1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a       <= AP'(i_a);
            r_b       <= i_b;
            r_cnt     <= '0;
            r_acc     <= '0;
            r_acc_idx <= '0;
        end else begin
            if (r_busy) begin
                r_pp  <= PP'(r_a[CHUNK_BITS-1:0]) * PP'(r_b);
                r_a   <= r_a >> CHUNK_BITS;
                r_cnt <= r_cnt + CW'(1);
            end
            if (r_pp_valid) begin
                r_acc     <= r_acc + (PW'(r_pp) << (CHUNK_BITS * r_acc_idx));
                r_acc_idx <= r_acc_idx + CW'(1);
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

`default_nettype wire

>>> hw/rtl/gpr_datapath.sv
// Datapath: configuration registers, population state, propensity products,
// prefix-sum reaction selection, count update and the output register.
// Depends on gpr_pkg and gpr_mul.
`default_nettype none

module gpr_datapath #(
    parameter int COUNT_BITS  = 20,
    parameter int RANDOM_BITS = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    input  wire logic [gpr_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire logic [gpr_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  wire logic                                 i_start_run,
    input  wire logic [RANDOM_BITS-1:0]               i_select_random,
    input  wire logic [RANDOM_BITS-1:0]               i_mutation_random,
    input  wire logic                                 i_m_ready,
    output logic                                      o_m_valid,
    output gpr_pkg::t_outcome                         o_outcome,
    output gpr_pkg::t_reaction                        o_reaction,
    output logic [COUNT_BITS-1:0]                     o_wild_count,
    output logic [COUNT_BITS-1:0]                     o_mutant_count,
    input  wire gpr_pkg::t_dp_cmd                     i_cmd,
    output gpr_pkg::t_dp_stat                         o_stat
);
    import gpr_pkg::*;

    localparam int NW  = COUNT_BITS + 1;
    localparam int KP  = COEF_BITS + NW;
    localparam int KW  = KP - FRAC_BITS;
    localparam int DW  = KW + 1;
    localparam int TW  = 2 * COUNT_BITS + 21;
    localparam int LW  = TW + RANDOM_BITS + 1;
    localparam int BW0 = (NW > COEF_BITS) ? NW : COEF_BITS;
    localparam int BW  = (BW0 > RANDOM_BITS + 1) ? BW0 : RANDOM_BITS + 1;
    localparam int PW  = ((TW + CHUNK_BITS - 1) / CHUNK_BITS) * CHUNK_BITS + BW;
    localparam int MW  = RANDOM_BITS + FRAC_BITS + 1;

    logic [RATE_BITS-1:0]  r_brw;
    logic [RATE_BITS-1:0]  r_brm;
    logic [RATE_BITS-1:0]  r_dbm;
    logic [COEF_BITS-1:0]  r_alpha;
    logic [COEF_BITS-1:0]  r_tc;
    logic [PROB_BITS-1:0]  r_mp;
    logic [COUNT_BITS-1:0] r_init;
    logic [COUNT_BITS-1:0] r_thr;

    logic [COUNT_BITS-1:0] r_wild;
    logic [COUNT_BITS-1:0] r_mut;
    t_outcome              r_outcome;

    logic [RANDOM_BITS-1:0] r_sel;
    logic [RANDOM_BITS-1:0] r_mrand;
    t_mul_op                r_op;
    logic [KW-1:0]          r_k;
    logic [2*COUNT_BITS-1:0] r_wm;
    logic [TW-1:0]          r_prop [NUM_PROP];
    logic [TW-1:0]          r_total;
    logic [TW-1:0]          r_prefix;
    logic [LW-1:0]          r_lhs;
    logic                   r_found;
    logic [PROP_IDX_BITS-1:0] r_rxn_idx;

    logic                   r_out_valid;
    t_outcome               r_out_outcome;
    t_reaction              r_out_rxn;
    logic [COUNT_BITS-1:0]  r_out_wild;
    logic [COUNT_BITS-1:0]  r_out_mut;

    logic [TW-1:0]          mul_a;
    logic [BW-1:0]          mul_b;
    logic                   mul_done;
    logic [PW-1:0]          mul_p;

    logic [TW-1:0]          n_prefix;
    logic [LW-1:0]          scan_rhs;
    logic [MW-1:0]          mut_lhs;
    logic [MW-1:0]          mut_rhs;
    logic                   mut_hit;
    t_reaction              rxn;
    logic [COUNT_BITS-1:0]  n_wild;
    logic [COUNT_BITS-1:0]  n_mut;
    t_outcome               end_outcome;
    t_outcome               react_outcome;
    logic                   out_free;

    function automatic t_outcome settle(input logic [COUNT_BITS-1:0] w,
                                        input logic [COUNT_BITS-1:0] m,
                                        input logic [COUNT_BITS-1:0] thr,
                                        input t_outcome              cur);
        t_outcome res;
        res = cur;
        if ((w == '0) && (m == '0)) begin
            res = OUTCOME_EXTINCT;
        end else if (m > thr) begin
            res = OUTCOME_RESCUED;
        end
        return res;
    endfunction

    gpr_mul #(
        .A_BITS (TW),
        .B_BITS (BW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    always_comb begin
        unique case (i_cmd.mul_op)
            MOP_CROWD: begin
                mul_a = TW'(r_alpha);
                mul_b = BW'(NW'(r_wild) + NW'(r_mut));
            end
            MOP_WM: begin
                mul_a = TW'(r_wild);
                mul_b = BW'(r_mut);
            end
            MOP_A0: begin
                mul_a = TW'(r_brw);
                mul_b = BW'(r_wild);
            end
            MOP_A1: begin
                mul_a = TW'(r_brm);
                mul_b = BW'(r_mut);
            end
            MOP_A2: begin
                mul_a = TW'(DW'(ONE_Q16) + DW'(r_k));
                mul_b = BW'(r_wild);
            end
            MOP_A3: begin
                mul_a = TW'(DW'(r_dbm) + DW'(r_k));
                mul_b = BW'(r_mut);
            end
            MOP_A4: begin
                mul_a = TW'(r_wm);
                mul_b = BW'(r_tc);
            end
            MOP_LHS: begin
                mul_a = r_total;
                mul_b = BW'((RANDOM_BITS + 1)'(r_sel) + (RANDOM_BITS + 1)'(1));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prefix = r_prefix + r_prop[i_cmd.idx];
    assign scan_rhs = LW'({n_prefix, {RANDOM_BITS{1'b0}}});

    assign mut_lhs = {(RANDOM_BITS + 1)'(r_mrand) + (RANDOM_BITS + 1)'(1),
                      {FRAC_BITS{1'b0}}};
    assign mut_rhs = {r_mp, {RANDOM_BITS{1'b0}}};
    assign mut_hit = (mut_lhs <= mut_rhs);

    always_comb begin
        rxn    = r_found ? t_reaction'(r_rxn_idx) : RXN_TRANSFER;
        n_wild = r_wild;
        n_mut  = r_mut;
        unique case (rxn)
            RXN_WILD_BIRTH: begin
                if (mut_hit) begin
                    if (r_mut != '1) begin
                        n_mut = r_mut + COUNT_BITS'(1);
                    end
                end else if (r_wild != '1) begin
                    n_wild = r_wild + COUNT_BITS'(1);
                end
            end
            RXN_MUTANT_BIRTH: begin
                if (r_mut != '1) begin
                    n_mut = r_mut + COUNT_BITS'(1);
                end
            end
            RXN_WILD_DEATH: begin
                if (r_wild != '0) begin
                    n_wild = r_wild - COUNT_BITS'(1);
                end
            end
            RXN_MUTANT_DEATH: begin
                if (r_mut != '0) begin
                    n_mut = r_mut - COUNT_BITS'(1);
                end
            end
            default: begin
                if ((r_wild != '0) && (r_mut != '0)) begin
                    n_wild = r_wild - COUNT_BITS'(1);
                    if (r_mut != '1) begin
                        n_mut = r_mut + COUNT_BITS'(1);
                    end
                end
            end
        endcase
        react_outcome = settle(n_wild, n_mut, r_thr, OUTCOME_RUNNING);
    end

    always_comb begin
        priority if (r_outcome != OUTCOME_RUNNING) begin
            end_outcome = r_outcome;
        end else if (r_dbm >= r_brm) begin
            end_outcome = OUTCOME_NOT_VIABLE;
        end else begin
            end_outcome = settle(r_wild, r_mut, r_thr, OUTCOME_RUNNING);
        end
    end

    assign out_free = !r_out_valid || i_m_ready;

    assign o_stat.must_end = (end_outcome != OUTCOME_RUNNING);
    assign o_stat.mul_done = mul_done;
    assign o_stat.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brw     <= RATE_RESET;
            r_brm     <= RATE_RESET;
            r_dbm     <= RATE_RESET;
            r_alpha   <= '0;
            r_tc      <= '0;
            r_mp      <= '0;
            r_init    <= COUNT_BITS'(INIT_WILD_RESET);
            r_thr     <= COUNT_BITS'(THRESHOLD_RESET);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BIRTH_RATE_WILD:   r_brw   <= i_cfg_data[RATE_BITS-1:0];
                CFG_BIRTH_RATE_MUTANT: r_brm   <= i_cfg_data[RATE_BITS-1:0];
                CFG_DEATH_BASE_MUTANT: r_dbm   <= i_cfg_data[RATE_BITS-1:0];
                CFG_CROWDING:          r_alpha <= i_cfg_data[COEF_BITS-1:0];
                CFG_TRANSFER:          r_tc    <= i_cfg_data[COEF_BITS-1:0];
                CFG_MUTATION_PROB:     r_mp    <= i_cfg_data[PROB_BITS-1:0];
                CFG_INITIAL_WILD:      r_init  <= i_cfg_data[COUNT_BITS-1:0];
                CFG_RESCUE_THRESHOLD:  r_thr   <= i_cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wild      <= COUNT_BITS'(INIT_WILD_RESET);
            r_mut       <= '0;
            r_outcome   <= OUTCOME_RUNNING;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_in && i_start_run) begin
                r_wild    <= r_init;
                r_mut     <= '0;
                r_outcome <= OUTCOME_RUNNING;
            end else if (i_cmd.commit_end) begin
                r_outcome <= end_outcome;
            end else if (i_cmd.commit_react) begin
                r_wild    <= n_wild;
                r_mut     <= n_mut;
                r_outcome <= react_outcome;
            end
            if (i_cmd.commit_end || i_cmd.commit_react) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sel    <= i_select_random;
            r_mrand  <= i_mutation_random;
            r_total  <= '0;
            r_prefix <= '0;
            r_found  <= 1'b0;
        end
        if (i_cmd.mul_start) begin
            r_op <= i_cmd.mul_op;
        end
        if (mul_done) begin
            unique case (r_op)
                MOP_CROWD: r_k       <= mul_p[KP-1:FRAC_BITS];
                MOP_WM:    r_wm      <= mul_p[2*COUNT_BITS-1:0];
                MOP_A0:    r_prop[0] <= mul_p[TW-1:0];
                MOP_A1:    r_prop[1] <= mul_p[TW-1:0];
                MOP_A2:    r_prop[2] <= mul_p[TW-1:0];
                MOP_A3:    r_prop[3] <= mul_p[TW-1:0];
                MOP_A4:    r_prop[4] <= mul_p[TW+FRAC_BITS-1:FRAC_BITS];
                MOP_LHS:   r_lhs     <= mul_p[LW-1:0];
                default: ;
            endcase
        end
        if (i_cmd.sum_step) begin
            r_total <= r_total + r_prop[i_cmd.idx];
        end
        if (i_cmd.scan_step) begin
            r_prefix <= n_prefix;
            if (!r_found && (r_lhs <= scan_rhs)) begin
                r_found   <= 1'b1;
                r_rxn_idx <= i_cmd.idx;
            end
        end
        if (i_cmd.commit_end) begin
            r_out_outcome <= end_outcome;
            r_out_rxn     <= RXN_NONE;
            r_out_wild    <= r_wild;
            r_out_mut     <= r_mut;
        end else if (i_cmd.commit_react) begin
            r_out_outcome <= react_outcome;
            r_out_rxn     <= rxn;
            r_out_wild    <= n_wild;
            r_out_mut     <= n_mut;
        end
    end

    assign o_m_valid      = r_out_valid;
    assign o_outcome      = r_out_outcome;
    assign o_reaction     = r_out_rxn;
    assign o_wild_count   = r_out_wild;
    assign o_mutant_count = r_out_mut;

endmodule

`default_nettype wire

>>> hw/rtl/gpr_ctrl.sv
// Controller state machine: accepts an item, sequences the products, the
// propensity sum and the prefix scan, and commits the result.
// Depends on gpr_pkg.
`default_nettype none

module gpr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_valid,
    output logic               o_s_ready,
    output gpr_pkg::t_dp_cmd   o_cmd,
    input  wire gpr_pkg::t_dp_stat i_stat
);
    import gpr_pkg::*;

    localparam logic [PROP_IDX_BITS-1:0] LAST_IDX = PROP_IDX_BITS'(NUM_PROP - 1);

    t_state                   r_state;
    t_state                   n_state;
    t_mul_op                  r_op;
    t_mul_op                  n_op;
    logic [PROP_IDX_BITS-1:0] r_idx;
    logic [PROP_IDX_BITS-1:0] n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= MOP_CROWD;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_idx     = r_idx;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.must_end) begin
                    if (i_stat.out_free) begin
                        o_cmd.commit_end = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end else begin
                    n_op    = MOP_CROWD;
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_op    = r_op;
                n_state         = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_op = r_op;
                if (i_stat.mul_done) begin
                    priority if (r_op == MOP_LHS) begin
                        n_idx   = '0;
                        n_state = ST_SCAN;
                    end else if (r_op == MOP_A4) begin
                        n_idx   = '0;
                        n_state = ST_SUM;
                    end else begin
                        n_op    = t_mul_op'(r_op + 3'd1);
                        n_state = ST_ISSUE;
                    end
                end
            end
            ST_SUM: begin
                o_cmd.sum_step = 1'b1;
                o_cmd.idx      = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_op    = MOP_LHS;
                    n_state = ST_ISSUE;
                end else begin
                    n_idx = r_idx + PROP_IDX_BITS'(1);
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.idx       = r_idx;
                if (r_idx == LAST_IDX) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_idx = r_idx + PROP_IDX_BITS'(1);
                end
            end
            ST_UPDATE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit_react = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/gillespie_plasmid_rescue_step.sv
// Top level of the Gillespie direct-method step for wild and mutant cells.
// Depends on gpr_pkg, gpr_ctrl and gpr_datapath.
//
//   Port group   Dir   Payload
//   i_s_axis_*   in    tuser: start_run; tdata: select_random, mutation_random
//   i_cfg_*      in    index: register number; data: register value
//   o_m_axis_*   out   tuser: outcome, reaction; tdata: wild_count, mutant_count
//
// Each item sends seven products through one 32-bit-chunk multiplier,
// then takes five sum steps, an eighth product for the selection bound and
// five scan steps. An item that ends the run before a reaction is committed
// straight from the check state. Reset is synchronous and active low. A new
// item is taken while the last result waits in the output register; a
// stalled output holds the block only when the next result is due.
`default_nettype none

module gillespie_plasmid_rescue_step #(
    parameter int COUNT_BITS  = 20,
    parameter int RANDOM_BITS = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       i_cfg_valid,
    output logic                                            o_cfg_ready,
    input  wire logic [gpr_pkg::CFG_INDEX_BITS-1:0]         i_cfg_index,
    input  wire logic [gpr_pkg::CFG_DATA_BITS-1:0]          i_cfg_data,
    input  wire logic                                       i_s_axis_tvalid,
    output logic                                            o_s_axis_tready,
    // select_random, mutation_random
    input  wire logic [((2*RANDOM_BITS+7)/8)*8-1:0]         i_s_axis_tdata,
    // start_run
    input  wire logic                                       i_s_axis_tuser,
    output logic                                            o_m_axis_tvalid,
    input  wire logic                                       i_m_axis_tready,
    // wild_count, mutant_count
    output logic [((2*COUNT_BITS+7)/8)*8-1:0]               o_m_axis_tdata,
    // outcome, reaction
    output logic [gpr_pkg::OUT_USER_BITS-1:0]               o_m_axis_tuser
);
    import gpr_pkg::*;

    localparam int OUT_DATA_BITS = ((2 * COUNT_BITS + 7) / 8) * 8;

    t_dp_cmd               cmd;
    t_dp_stat              stat;
    t_outcome              outcome;
    t_reaction             reaction;
    logic [COUNT_BITS-1:0] wild_count;
    logic [COUNT_BITS-1:0] mutant_count;

    gpr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .o_cmd     (cmd),
        .i_stat    (stat)
    );

    gpr_datapath #(
        .COUNT_BITS  (COUNT_BITS),
        .RANDOM_BITS (RANDOM_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_start_run       (i_s_axis_tuser),
        .i_select_random   (i_s_axis_tdata[RANDOM_BITS-1:0]),
        .i_mutation_random (i_s_axis_tdata[2*RANDOM_BITS-1:RANDOM_BITS]),
        .i_m_ready         (i_m_axis_tready),
        .o_m_valid         (o_m_axis_tvalid),
        .o_outcome         (outcome),
        .o_reaction        (reaction),
        .o_wild_count      (wild_count),
        .o_mutant_count    (mutant_count),
        .i_cmd             (cmd),
        .o_stat            (stat)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = OUT_DATA_BITS'({mutant_count, wild_count});
    assign o_m_axis_tuser = {reaction, outcome};

endmodule

`default_nettype wire

>>> hw/rtl/gpr_checker.sv
// Port-level checker for the Gillespie step block, bound to the top level.
// Depends on gpr_pkg.
`default_nettype none

module gpr_checker #(
    parameter int COUNT_BITS  = 20,
    parameter int RANDOM_BITS = 16
) (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 i_cfg_valid,
    input wire logic                                 o_cfg_ready,
    input wire logic [gpr_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input wire logic [gpr_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input wire logic                                 i_s_axis_tvalid,
    input wire logic                                 o_s_axis_tready,
    input wire logic [((2*RANDOM_BITS+7)/8)*8-1:0]   i_s_axis_tdata,
    input wire logic                                 i_s_axis_tuser,
    input wire logic                                 o_m_axis_tvalid,
    input wire logic                                 i_m_axis_tready,
    input wire logic [((2*COUNT_BITS+7)/8)*8-1:0]    o_m_axis_tdata,
    input wire logic [gpr_pkg::OUT_USER_BITS-1:0]    o_m_axis_tuser
);
    import gpr_pkg::*;

    logic cfg_seen;
    logic [RANDOM_BITS-1:0] in_sel;

    assign cfg_seen = i_cfg_valid && o_cfg_ready && (i_cfg_index == i_cfg_index)
                      && (i_cfg_data == i_cfg_data);
    assign in_sel   = i_s_axis_tdata[RANDOM_BITS-1:0];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output changed while stalled");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (in_sel == in_sel) && !cfg_seen
            |=> !o_s_axis_tready)
        else $error("second item taken while one is in progress");

    a_none_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[4:2] == RXN_NONE)
            |-> (o_m_axis_tuser[1:0] != OUTCOME_RUNNING))
        else $error("no reaction reported on a running step");

    a_extinct_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[1:0] == OUTCOME_EXTINCT)
            |-> (o_m_axis_tdata[2*COUNT_BITS-1:0] == '0))
        else $error("extinct outcome with cells left");

endmodule

bind gillespie_plasmid_rescue_step gpr_checker #(
    .COUNT_BITS  (COUNT_BITS),
    .RANDOM_BITS (RANDOM_BITS)
) u_gpr_checker (.*);

`default_nettype wire

>>> sim/gpr_census_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the plasmid rescue step block: mirrors every register write,
// predicts the result of each accepted input transfer and compares every output
// transfer with it field by field. Depends on gpr_pkg.
module gpr_census_checker #(
    parameter int COUNT_BITS  = 20,
    parameter int RANDOM_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic                                   i_cfg_ready,
    input  logic [gpr_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [gpr_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    // select_random, mutation_random
    input  logic [((2*RANDOM_BITS+7)/8)*8-1:0]     i_in_data,
    // start_run
    input  logic                                   i_in_user,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    // wild_count, mutant_count
    input  logic [((2*COUNT_BITS+7)/8)*8-1:0]      i_out_data,
    // outcome, reaction
    input  logic [gpr_pkg::OUT_USER_BITS-1:0]      i_out_user,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import gpr_pkg::*;

    typedef struct packed {
        t_outcome                outcome;
        t_reaction               reaction;
        logic [COUNT_BITS-1:0]   wild;
        logic [COUNT_BITS-1:0]   mutant;
    } t_census;

    logic [RATE_BITS-1:0]  birth_wild;
    logic [RATE_BITS-1:0]  birth_mutant;
    logic [RATE_BITS-1:0]  death_mutant;
    logic [COEF_BITS-1:0]  crowding;
    logic [COEF_BITS-1:0]  transfer;
    logic [PROB_BITS-1:0]  mut_prob;
    logic [COUNT_BITS-1:0] init_wild;
    logic [COUNT_BITS-1:0] threshold;

    logic [COUNT_BITS-1:0] colony_wild;
    logic [COUNT_BITS-1:0] colony_mutant;
    t_outcome              colony_outcome;

    t_census expected_census[$];
    int      fail_total = 0;

    task automatic report_mismatch(input string what);
        if (fail_total < 100)
            $display("ERROR at %0t: %s", $time, what);
        fail_total++;
    endtask

    function automatic logic [COUNT_BITS-1:0] grow_count(input logic [COUNT_BITS-1:0] n);
        return (n == '1) ? n : n + 1'b1;
    endfunction

    function automatic void settle_colony();
        if (colony_wild == '0 && colony_mutant == '0)
            colony_outcome = OUTCOME_EXTINCT;
        else if (colony_mutant > threshold)
            colony_outcome = OUTCOME_RESCUED;
    endfunction

    // The reaction is the first whose prefix sum covers the selection fraction
    // of the total propensity; all products are kept exact at 128 bits.
    function automatic t_reaction choose_reaction(input logic [RANDOM_BITS-1:0] sel);
        logic [127:0] w, m, k, total, lhs, prefix;
        logic [127:0] prop [NUM_PROP];
        w = 128'(colony_wild);
        m = 128'(colony_mutant);
        k = (128'(crowding) * (w + m)) >> FRAC_BITS;
        prop[0] = w * 128'(birth_wild);
        prop[1] = m * 128'(birth_mutant);
        prop[2] = w * (128'(ONE_Q16) + k);
        prop[3] = m * (128'(death_mutant) + k);
        prop[4] = (w * m * 128'(transfer)) >> FRAC_BITS;
        total = prop[0] + prop[1] + prop[2] + prop[3] + prop[4];
        lhs = total * (128'(sel) + 128'd1);
        prefix = '0;
        for (int r = 0; r < NUM_PROP; r++) begin
            prefix = prefix + prop[r];
            if (lhs <= (prefix << RANDOM_BITS))
                return t_reaction'(r);
        end
        return RXN_TRANSFER;
    endfunction

    function automatic t_census step_colony(input logic start,
                                            input logic [RANDOM_BITS-1:0] sel,
                                            input logic [RANDOM_BITS-1:0] mut);
        t_reaction rxn;
        t_census   res;
        rxn = RXN_NONE;
        if (start) begin
            colony_wild    = init_wild;
            colony_mutant  = '0;
            colony_outcome = OUTCOME_RUNNING;
        end
        if (colony_outcome == OUTCOME_RUNNING) begin
            if (death_mutant >= birth_mutant) begin
                colony_outcome = OUTCOME_NOT_VIABLE;
            end else begin
                settle_colony();
                if (colony_outcome == OUTCOME_RUNNING) begin
                    rxn = choose_reaction(sel);
                    case (rxn)
                        RXN_WILD_BIRTH: begin
                            if (((64'(mut) + 64'd1) << FRAC_BITS)
                                    <= (64'(mut_prob) << RANDOM_BITS))
                                colony_mutant = grow_count(colony_mutant);
                            else
                                colony_wild = grow_count(colony_wild);
                        end
                        RXN_MUTANT_BIRTH: colony_mutant = grow_count(colony_mutant);
                        RXN_WILD_DEATH: begin
                            if (colony_wild != '0)
                                colony_wild = colony_wild - 1'b1;
                        end
                        RXN_MUTANT_DEATH: begin
                            if (colony_mutant != '0)
                                colony_mutant = colony_mutant - 1'b1;
                        end
                        default: begin
                            if (colony_wild != '0 && colony_mutant != '0) begin
                                colony_wild   = colony_wild - 1'b1;
                                colony_mutant = grow_count(colony_mutant);
                            end
                        end
                    endcase
                    settle_colony();
                end
            end
        end
        res.outcome  = colony_outcome;
        res.reaction = rxn;
        res.wild     = colony_wild;
        res.mutant   = colony_mutant;
        return res;
    endfunction

    always @(posedge i_clk) begin : track
        t_census want;
        if (!i_rst_n) begin
            birth_wild     = RATE_RESET;
            birth_mutant   = RATE_RESET;
            death_mutant   = RATE_RESET;
            crowding       = '0;
            transfer       = '0;
            mut_prob       = '0;
            init_wild      = INIT_WILD_RESET[COUNT_BITS-1:0];
            threshold      = THRESHOLD_RESET[COUNT_BITS-1:0];
            colony_wild    = INIT_WILD_RESET[COUNT_BITS-1:0];
            colony_mutant  = '0;
            colony_outcome = OUTCOME_RUNNING;
            expected_census.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BIRTH_RATE_WILD:   birth_wild   = i_cfg_data[RATE_BITS-1:0];
                    CFG_BIRTH_RATE_MUTANT: birth_mutant = i_cfg_data[RATE_BITS-1:0];
                    CFG_DEATH_BASE_MUTANT: death_mutant = i_cfg_data[RATE_BITS-1:0];
                    CFG_CROWDING:          crowding     = i_cfg_data[COEF_BITS-1:0];
                    CFG_TRANSFER:          transfer     = i_cfg_data[COEF_BITS-1:0];
                    CFG_MUTATION_PROB:     mut_prob     = i_cfg_data[PROB_BITS-1:0];
                    CFG_INITIAL_WILD:      init_wild    = i_cfg_data[COUNT_BITS-1:0];
                    default:               threshold    = i_cfg_data[COUNT_BITS-1:0];
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_census.size() == 0) begin
                    report_mismatch($sformatf("result transfer with nothing expected, data %0h",
                                              i_out_data));
                end else begin
                    want = expected_census.pop_front();
                    if (i_out_user[1:0] != want.outcome)
                        report_mismatch($sformatf("outcome expected %0d got %0d",
                                                  want.outcome, i_out_user[1:0]));
                    if (i_out_user[4:2] != want.reaction)
                        report_mismatch($sformatf("reaction expected %0d got %0d",
                                                  want.reaction, i_out_user[4:2]));
                    if (i_out_data[COUNT_BITS-1:0] != want.wild)
                        report_mismatch($sformatf("wild_count expected %0d got %0d",
                                                  want.wild, i_out_data[COUNT_BITS-1:0]));
                    if (i_out_data[2*COUNT_BITS-1:COUNT_BITS] != want.mutant)
                        report_mismatch($sformatf("mutant_count expected %0d got %0d",
                                        want.mutant, i_out_data[2*COUNT_BITS-1:COUNT_BITS]));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_census.push_back(step_colony(i_in_user,
                                                      i_in_data[RANDOM_BITS-1:0],
                                                      i_in_data[2*RANDOM_BITS-1:RANDOM_BITS]));
        end
        o_pending    <= expected_census.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> sim/tb_gillespie_plasmid_rescue_step.sv
`timescale 1ns / 1ps
// Testbench top for the plasmid rescue step block: drives register writes and
// step items with random gaps and output stalls, and gives the verdict.
// Depends on gpr_pkg, gpr_census_checker and the block itself.
module tb_gillespie_plasmid_rescue_step;
    import gpr_pkg::*;

    localparam int COUNT_BITS  = 20;
    localparam int RANDOM_BITS = 16;
    localparam int S_DATA_W    = ((2*RANDOM_BITS+7)/8)*8;
    localparam int M_DATA_W    = ((2*COUNT_BITS+7)/8)*8;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [RATE_BITS-1:0]  birth_wild;
        logic [RATE_BITS-1:0]  birth_mutant;
        logic [RATE_BITS-1:0]  death_mutant;
        logic [COEF_BITS-1:0]  crowding;
        logic [COEF_BITS-1:0]  transfer;
        logic [PROB_BITS-1:0]  mut_prob;
        logic [COUNT_BITS-1:0] init_wild;
        logic [COUNT_BITS-1:0] threshold;
    } t_culture;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [S_DATA_W-1:0]       s_tdata = '0;
    logic                      s_tuser = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [M_DATA_W-1:0]       m_tdata;
    logic [OUT_USER_BITS-1:0]  m_tuser;
    int                        fail_count;
    int                        pending;
    int                        idle_pct = 0;
    int                        hold_ticket = 0;

    gillespie_plasmid_rescue_step #(
        .COUNT_BITS  (COUNT_BITS),
        .RANDOM_BITS (RANDOM_BITS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    gpr_census_checker #(
        .COUNT_BITS  (COUNT_BITS),
        .RANDOM_BITS (RANDOM_BITS)
    ) checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_in_user    (s_tuser),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .i_out_user   (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // The result side stalls in random bursts, and holds off for a long stretch
    // whenever the stimulus asks for it so that the block backs up.
    initial begin : sink
        int stall;
        int hold_served;
        stall = 0;
        hold_served = 0;
        forever begin
            @(negedge clk);
            if (hold_served != hold_ticket) begin
                hold_served = hold_ticket;
                stall = HOLD_CYCLES;
            end else if (stall == 0 && $urandom_range(0, 99) < idle_pct) begin
                stall = $urandom_range(1, 15);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [RANDOM_BITS-1:0] pick_fraction();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return RANDOM_BITS'($urandom);
        endcase
    endfunction

    function automatic t_culture lively_culture();
        t_culture c;
        c.birth_mutant = RATE_BITS'($urandom_range(70000, 200000));
        c.death_mutant = RATE_BITS'($urandom_range(c.birth_mutant / 2, c.birth_mutant - 1));
        c.birth_wild   = RATE_BITS'($urandom_range(40000, 120000));
        c.crowding     = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h40_0000);
        c.transfer     = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        case ($urandom_range(0, 2))
            0:       c.mut_prob = PROB_BITS'($urandom_range(0, 4096));
            1:       c.mut_prob = PROB_BITS'($urandom_range(0, 65536));
            default: c.mut_prob = PROB_BITS'($urandom_range(0, 131071));
        endcase
        c.init_wild = COUNT_BITS'($urandom_range(1, 60));
        c.threshold = COUNT_BITS'($urandom_range(0, 40));
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_culture(input t_culture c);
        write_reg(CFG_BIRTH_RATE_WILD,   CFG_DATA_BITS'(c.birth_wild));
        write_reg(CFG_BIRTH_RATE_MUTANT, CFG_DATA_BITS'(c.birth_mutant));
        write_reg(CFG_DEATH_BASE_MUTANT, CFG_DATA_BITS'(c.death_mutant));
        write_reg(CFG_CROWDING,          CFG_DATA_BITS'(c.crowding));
        write_reg(CFG_TRANSFER,          CFG_DATA_BITS'(c.transfer));
        write_reg(CFG_MUTATION_PROB,     CFG_DATA_BITS'(c.mut_prob));
        write_reg(CFG_INITIAL_WILD,      CFG_DATA_BITS'(c.init_wild));
        write_reg(CFG_RESCUE_THRESHOLD,  CFG_DATA_BITS'(c.threshold));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic start,
                             input logic [RANDOM_BITS-1:0] sel,
                             input logic [RANDOM_BITS-1:0] mut);
        int gap;
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 15);
            repeat (gap) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= S_DATA_W'({mut, sel});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    // Mostly whole runs that open with a start transfer; a few runs open
    // without one and a few carry a stray restart in the middle.
    task automatic run_phase(input int n_items);
        int  left;
        int  span;
        logic opened;
        left = n_items;
        while (left > 0) begin
            span = $urandom_range(1, 60);
            opened = ($urandom_range(0, 9) != 0);
            for (int j = 0; j < span && left > 0; j++) begin
                send_item((j == 0 && opened) || ($urandom_range(0, 99) < 3),
                          pick_fraction(), pick_fraction());
                left--;
            end
        end
    endtask

    initial begin : stimulus
        t_culture c;
        int       ph;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings make the mutant class not viable at once.
        send_item(1'b0, '0, '0);
        send_item(1'b0, '1, '1);
        send_item(1'b1, pick_fraction(), pick_fraction());
        drain();

        c = lively_culture();
        c.mut_prob  = ONE_Q16;
        c.init_wild = COUNT_BITS'(4);
        c.threshold = COUNT_BITS'(20);
        c.transfer  = 32'h8000_0000;
        apply_culture(c);
        send_item(1'b1, '0, '0);
        send_item(1'b0, '1, '1);
        send_item(1'b0, '0, '1);
        send_item(1'b0, '1, '0);
        repeat (4) send_item(1'b0, pick_fraction(), pick_fraction());
        drain();

        c.init_wild = '0;
        apply_culture(c);
        send_item(1'b1, pick_fraction(), pick_fraction());
        send_item(1'b0, pick_fraction(), pick_fraction());
        drain();

        c.init_wild = COUNT_BITS'(3);
        c.threshold = '0;
        c.mut_prob  = '1;
        c.crowding  = '0;
        c.transfer  = '0;
        apply_culture(c);
        send_item(1'b1, '0, '1);
        send_item(1'b0, pick_fraction(), pick_fraction());
        drain();

        c.init_wild    = '1;
        c.birth_wild   = '1;
        c.birth_mutant = '1;
        c.death_mutant = '0;
        c.threshold    = '1;
        c.mut_prob     = '0;
        apply_culture(c);
        send_item(1'b1, '0, '0);
        repeat (3) send_item(1'b0, pick_fraction(), pick_fraction());
        drain();

        c.crowding = '1;
        c.transfer = '1;
        apply_culture(c);
        send_item(1'b1, '1, '1);
        send_item(1'b0, '1, '0);
        send_item(1'b0, '0, '0);
        drain();

        c.death_mutant = c.birth_mutant;
        apply_culture(c);
        send_item(1'b1, pick_fraction(), pick_fraction());
        drain();

        for (ph = 0; ph < 14; ph++) begin
            c = lively_culture();
            if (ph == 5) begin
                c.init_wild = COUNT_BITS'($urandom_range(0, 20'hF_FFFF));
                c.threshold = COUNT_BITS'($urandom_range(0, 20'hF_FFFF));
            end
            if (ph == 9) begin
                c.birth_wild   = RATE_BITS'($urandom);
                c.birth_mutant = '1;
                c.death_mutant = RATE_BITS'($urandom);
            end
            idle_pct = (ph >= 12) ? 0 : 10 * (ph % 4);
            apply_culture(c);
            if (ph == 3) begin
                @(posedge clk);
                hold_ticket++;
            end
            run_phase(90);
            drain();
        end

        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
